// ----- rtl/rpu_pkg.sv -----
// rpu_pkg: shared constants, types and function of the raw pixel unpacker
`timescale 1ns / 1ps

package rpu_pkg;

	// picture dimension registers and frame pixel count
	localparam int DIM_W = 14;
	localparam int CNT_W = 2 * DIM_W;

	// group storage and pixel lanes
	localparam int GROUP_MAX   = 24;
	localparam int POS_W       = $clog2(GROUP_MAX);
	localparam int PIX_MAX     = 16;
	localparam int LANE_W      = $clog2(PIX_MAX);
	localparam int PIX_W       = 12;
	localparam int BYTE_W      = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration port
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// packing modes
	localparam logic [MODE_W-1:0] MODE_10P_LSB = 3'd0;
	localparam logic [MODE_W-1:0] MODE_12P_LSB = 3'd1;
	localparam logic [MODE_W-1:0] MODE_10G_20  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_12G_3   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_12G_24  = 3'd4;

	typedef logic [GROUP_MAX-1:0][BYTE_W-1:0] group_bytes_t;

	// one finished group, ready to be sent out pixel by pixel
	typedef struct packed {
		logic [PIX_MAX-1:0][PIX_W-1:0] pix;
		logic [LANE_W-1:0]             last_idx;
		logic                          frame_end;
	} group_t;

	typedef struct packed {
		logic full;
		logic avail;
	} queue_status_t;

	typedef struct packed {
		logic              ok;
		logic [POS_W-1:0]  last_byte;
		logic [LANE_W-1:0] last_pix;
	} shape_t;

	function automatic shape_t group_shape(input logic [MODE_W-1:0] mode);
		shape_t s;
		s = '0;
		unique case (mode)
			MODE_10P_LSB: s = '{ok: 1'b1, last_byte: 5'd4,  last_pix: 4'd3};
			MODE_12P_LSB: s = '{ok: 1'b1, last_byte: 5'd2,  last_pix: 4'd1};
			MODE_10G_20:  s = '{ok: 1'b1, last_byte: 5'd19, last_pix: 4'd15};
			MODE_12G_3:   s = '{ok: 1'b1, last_byte: 5'd2,  last_pix: 4'd1};
			MODE_12G_24:  s = '{ok: 1'b1, last_byte: 5'd23, last_pix: 4'd15};
			default:      s = '0;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/packed_raw_pixel_unpacker.sv -----
// packed_raw_pixel_unpacker: top level of the packed raw pixel unpacker
`timescale 1ns / 1ps

// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------------------
// cfg       | cfg_write_en          | cfg_index, cfg_data
// in        | in_valid / in_stall   | data_byte, start_of_frame
// out       | out_valid / out_stall | pixel_value, last_in_group, last_in_frame
//
// one word in per cycle while in_stall is low; a completed group is unpacked into
// 2, 4 or 16 pixel lanes in the cycle its last byte is taken and queued, then pixels
// leave the queue one per cycle via the back's output register while out_stall is low.
// the two-entry group queue sets the input stall: in_stall is high only when it is full.
// reset clears positions, pixel count, queue and output valid; config regs reset to
// mode 0 and a 1 x 1 frame; the frame pixel count is registered from width and height.

module packed_raw_pixel_unpacker (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_write_en,
	input  logic [rpu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rpu_pkg::CFG_DATA_W-1:0]  cfg_data,
	// packed byte words
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rpu_pkg::BYTE_W-1:0]      data_byte,
	input  logic                            start_of_frame,
	// pixel words
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rpu_pkg::PIX_W-1:0]       pixel_value,
	output logic                            last_in_group,
	output logic                            last_in_frame
);

	logic [rpu_pkg::MODE_W-1:0]  mode_q;
	logic [rpu_pkg::DIM_W-1:0]   width_q;
	logic [rpu_pkg::DIM_W-1:0]   height_q;
	logic [rpu_pkg::CNT_W-1:0]   total_q;

	logic                        take;
	logic                        push;
	logic                        pop;
	rpu_pkg::group_t             push_entry;
	rpu_pkg::group_t             head;
	rpu_pkg::queue_status_t      q_status;

	// config registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= rpu_pkg::MODE_10P_LSB;
			width_q  <= rpu_pkg::DIM_W'(1);
			height_q <= rpu_pkg::DIM_W'(1);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				rpu_pkg::REG_MODE:   mode_q   <= cfg_data[rpu_pkg::MODE_W-1:0];
				rpu_pkg::REG_WIDTH:  width_q  <= cfg_data;
				rpu_pkg::REG_HEIGHT: height_q <= cfg_data;
				default:             mode_q   <= mode_q;
			endcase
		end
	end

	// frame pixel count, registered after the multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= rpu_pkg::CNT_W'(1);
		end else begin
			total_q <= rpu_pkg::CNT_W'(width_q) * rpu_pkg::CNT_W'(height_q);
		end
	end

	// input side stalls only on a full group queue
	assign in_stall = q_status.full;
	assign take     = in_valid && !in_stall;

	rpu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.mode           (mode_q),
		.total          (total_q),
		.take           (take),
		.data_byte      (data_byte),
		.start_of_frame (start_of_frame),
		.push           (push),
		.push_entry     (push_entry)
	);

	rpu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	rpu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.avail         (q_status.avail),
		.out_stall     (out_stall),
		.pop           (pop),
		.out_valid     (out_valid),
		.pixel_value   (pixel_value),
		.last_in_group (last_in_group),
		.last_in_frame (last_in_frame)
	);

endmodule

// ----- rtl/rpu_front.sv -----
// rpu_front: byte gathering, frame accounting and group unpacking into pixel lanes
`timescale 1ns / 1ps

module rpu_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [rpu_pkg::MODE_W-1:0]       mode,
	input  logic [rpu_pkg::CNT_W-1:0]        total,
	input  logic                             take,
	input  logic [rpu_pkg::BYTE_W-1:0]       data_byte,
	input  logic                             start_of_frame,
	output logic                             push,
	output rpu_pkg::group_t                  push_entry
);

	rpu_pkg::group_bytes_t        group_q;
	rpu_pkg::group_bytes_t        grp_next;
	logic [rpu_pkg::POS_W-1:0]    pos_q;
	logic [rpu_pkg::CNT_W-1:0]    emitted_q;

	rpu_pkg::shape_t              shape;
	logic [rpu_pkg::POS_W-1:0]    pos_base;
	logic [rpu_pkg::POS_W-1:0]    pos_eff;
	logic                         complete;
	logic [rpu_pkg::CNT_W-1:0]    done_cnt;
	logic [rpu_pkg::LANE_W:0]     npix;
	logic [rpu_pkg::CNT_W:0]      sum1;
	logic [rpu_pkg::CNT_W:0]      sum2;
	logic                         fits;

	logic [3:0][rpu_pkg::PIX_W-1:0] p10p;
	logic [1:0][rpu_pkg::PIX_W-1:0] p12p;
	logic [rpu_pkg::PIX_MAX-1:0][rpu_pkg::PIX_W-1:0] lane_pix;

	assign shape    = rpu_pkg::group_shape(mode);
	assign pos_base = start_of_frame ? '0 : pos_q;
	assign pos_eff  = (pos_base > shape.last_byte) ? '0 : pos_base;
	assign complete = (pos_eff == shape.last_byte);
	assign done_cnt = start_of_frame ? '0 : emitted_q;
	assign npix     = {1'b0, shape.last_pix} + 1'b1;
	assign sum1     = {1'b0, done_cnt} + (rpu_pkg::CNT_W+1)'(npix);
	assign sum2     = sum1 + (rpu_pkg::CNT_W+1)'(npix);
	assign fits     = (sum1 <= {1'b0, total});

	// group with the current byte in place
	always_comb begin
		grp_next          = group_q;
		grp_next[pos_eff] = data_byte;
	end

	// 10p and 12p lsb pixels
	assign p10p[0] = {2'b00, grp_next[1][1:0], grp_next[0]};
	assign p10p[1] = {2'b00, grp_next[2][3:0], grp_next[1][7:2]};
	assign p10p[2] = {2'b00, grp_next[3][5:0], grp_next[2][7:4]};
	assign p10p[3] = {2'b00, grp_next[4], grp_next[3][7:6]};
	assign p12p[0] = {grp_next[1][3:0], grp_next[0]};
	assign p12p[1] = {grp_next[2], grp_next[1][7:4]};

	// pixel lanes of the finished group
	always_comb begin
		lane_pix = '0;
		for (int k = 0; k < rpu_pkg::PIX_MAX; k++) begin
			unique case (mode)
				rpu_pkg::MODE_10P_LSB: lane_pix[k[3:0]] = p10p[k[1:0]];
				rpu_pkg::MODE_12P_LSB: lane_pix[k[3:0]] = p12p[k[0]];
				rpu_pkg::MODE_10G_20:  lane_pix[k[3:0]] =
					{2'b00, grp_next[rpu_pkg::POS_W'(k)],
					 grp_next[rpu_pkg::POS_W'(16 + (k >> 2))][{k[1:0], 1'b0} +: 2]};
				rpu_pkg::MODE_12G_3:   lane_pix[k[3:0]] =
					{grp_next[rpu_pkg::POS_W'(k[0])], grp_next[2][{k[0], 2'b00} +: 4]};
				rpu_pkg::MODE_12G_24:  lane_pix[k[3:0]] =
					{grp_next[rpu_pkg::POS_W'(k)],
					 grp_next[rpu_pkg::POS_W'(16 + (k >> 1))][{k[0], 2'b00} +: 4]};
				default:               lane_pix[k[3:0]] = '0;
			endcase
		end
	end

	// lanes, last lane index, frame end
	assign push_entry = {lane_pix, shape.last_pix, (sum2 > {1'b0, total})};
	assign push = take && shape.ok && complete && fits;

	always_ff @(posedge clk) begin
		if (take && shape.ok) begin
			group_q[pos_eff] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			emitted_q <= '0;
		end else if (take) begin
			if (shape.ok) begin
				pos_q     <= complete ? '0 : pos_eff + 1'b1;
				emitted_q <= (complete && fits) ? sum1[rpu_pkg::CNT_W-1:0] : done_cnt;
			end else if (start_of_frame) begin
				pos_q     <= '0;
				emitted_q <= '0;
			end
		end
	end

endmodule

// ----- rtl/rpu_queue.sv -----
// rpu_queue: short group queue between the front and the back
`timescale 1ns / 1ps

module rpu_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rpu_pkg::group_t        push_entry,
	input  logic                   pop,
	output rpu_pkg::group_t        head,
	output rpu_pkg::queue_status_t status
);

	rpu_pkg::group_t                  ent_q [rpu_pkg::QUEUE_DEPTH];
	logic [rpu_pkg::QPTR_W-1:0]       wr_q;
	logic [rpu_pkg::QPTR_W-1:0]       rd_q;
	logic [rpu_pkg::QCNT_W-1:0]       cnt_q;

	assign head         = ent_q[rd_q];
	assign status.full  = (cnt_q == rpu_pkg::QCNT_W'(rpu_pkg::QUEUE_DEPTH));
	assign status.avail = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/rpu_back.sv -----
// rpu_back: pixel sequencing from the queue head into the output register
`timescale 1ns / 1ps

module rpu_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rpu_pkg::group_t            head,
	input  logic                       avail,
	input  logic                       out_stall,
	output logic                       pop,
	output logic                       out_valid,
	output logic [rpu_pkg::PIX_W-1:0]  pixel_value,
	output logic                       last_in_group,
	output logic                       last_in_frame
);

	logic [rpu_pkg::LANE_W-1:0] k_q;
	logic                       valid_q;
	logic [rpu_pkg::PIX_W-1:0]  pix_q;
	logic                       lig_q;
	logic                       lif_q;
	logic                       load;
	logic                       at_last;

	assign load    = avail && (!valid_q || !out_stall);
	assign at_last = (k_q == head.last_idx);
	assign pop     = load && at_last;

	assign out_valid     = valid_q;
	assign pixel_value   = pix_q;
	assign last_in_group = lig_q;
	assign last_in_frame = lif_q;

	always_ff @(posedge clk) begin
		if (load) begin
			pix_q <= head.pix[k_q];
			lig_q <= at_last;
			lif_q <= at_last && head.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= at_last ? '0 : k_q + 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/rpu_checker.sv -----
// rpu_checker: port-level assertions for the unpacker, bound to the top level
`timescale 1ns / 1ps

module rpu_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [rpu_pkg::PIX_W-1:0]       pixel_value,
	input logic                            last_in_group,
	input logic                            last_in_frame
);

	// a held pixel word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_value)
			&& $stable(last_in_group) && $stable(last_in_frame))
		else $error("pixel word changed while stalled");

	// frame end only closes a group
	a_frame_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_in_frame |-> last_in_group)
		else $error("frame end without group end");

	// a full queue always has a pixel waiting at the output
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with nothing to send");

	// nothing comes out of reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("pixel word right after reset");

endmodule

bind packed_raw_pixel_unpacker rpu_checker u_rpu_checker (.*);
